// ----- rtl/core/pwfd_pkg.sv -----
// Shared types, widths and register codes for the pulse-width frame decoder.
package pwfd_pkg;

    localparam int TS_BITS    = 48;
    localparam int DUR_W      = 15;
    localparam int IDLE_W     = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int VALUE_W    = 16;
    localparam int COUNT_W    = 5;

    localparam logic [COUNT_W-1:0] BYTE_BITS = COUNT_W'(8);
    localparam logic [COUNT_W-1:0] WORD_BITS = COUNT_W'(16);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_LOW_MIN    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_LOW_MAX    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_START_HIGH_MIN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_START_HIGH_MAX = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_THRESHOLD  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_RESET     = CFG_IDX_W'(5);

    // Register reset values
    localparam logic [DUR_W-1:0]  RST_PRE_LOW_MIN    = DUR_W'(800);
    localparam logic [DUR_W-1:0]  RST_PRE_LOW_MAX    = DUR_W'(3000);
    localparam logic [DUR_W-1:0]  RST_START_HIGH_MIN = DUR_W'(28000);
    localparam logic [DUR_W-1:0]  RST_START_HIGH_MAX = DUR_W'(32000);
    localparam logic [DUR_W-1:0]  RST_BIT_THRESHOLD  = DUR_W'(6000);
    localparam logic [IDLE_W-1:0] RST_IDLE_RESET     = IDLE_W'(80000);

    typedef struct packed {
        logic [DUR_W-1:0]  pre_low_min;
        logic [DUR_W-1:0]  pre_low_max;
        logic [DUR_W-1:0]  start_high_min;
        logic [DUR_W-1:0]  start_high_max;
        logic [DUR_W-1:0]  bit_threshold;
        logic [IDLE_W-1:0] idle_reset_time;
    } cfg_t;

    // One classified pulse pair
    typedef struct packed {
        logic               is_pre;
        logic               is_start;
        logic               has_low;
        logic               bit_one;
        logic [TS_BITS-1:0] now;
    } cls_item_t;

    // Exclusive window test
    function automatic logic in_window(
        input logic [DUR_W-1:0] d,
        input logic [DUR_W-1:0] lo,
        input logic [DUR_W-1:0] hi
    );
        return (d > lo) && (d < hi);
    endfunction

endpackage

// ----- rtl/core/pwfd_front.sv -----
// Front stage: accepts pulse pairs and classifies them against the windows.
module pwfd_front
    import pwfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               first_level,
    input  logic [DUR_W-1:0]   first_duration,
    input  logic               second_level,
    input  logic [DUR_W-1:0]   second_duration,
    input  logic [TS_BITS-1:0] arrival_time,
    output logic               push_valid,
    input  logic               push_ready,
    output cls_item_t          push_item
);

    logic      stage_valid_reg;
    logic      stage_valid_next;
    cls_item_t stage_item_reg;
    cls_item_t cls;
    logic      in_take;
    logic [DUR_W-1:0] low_us;

    // Classification of the incoming request
    always_comb
    begin
        low_us       = (!first_level) ? first_duration : second_duration;
        cls.is_pre   = (!first_level &&
                        in_window(first_duration, cfg.pre_low_min, cfg.pre_low_max)) ||
                       (!second_level &&
                        in_window(second_duration, cfg.pre_low_min, cfg.pre_low_max));
        cls.is_start = (first_level &&
                        in_window(first_duration, cfg.start_high_min,
                                  cfg.start_high_max)) ||
                       (second_level &&
                        in_window(second_duration, cfg.start_high_min,
                                  cfg.start_high_max));
        cls.has_low  = !first_level || !second_level;
        cls.bit_one  = low_us < cfg.bit_threshold;
        cls.now      = arrival_time;
    end

    assign in_ready   = !stage_valid_reg || push_ready;
    assign in_take    = in_valid && in_ready;
    assign push_valid = stage_valid_reg;
    assign push_item  = stage_item_reg;

    // Stage valid flag
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stage_item_reg <= cls;
        end
    end

endmodule

// ----- rtl/core/pwfd_queue.sv -----
// Two-entry queue between the classifying front and the frame back end.
module pwfd_queue
    import pwfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  cls_item_t push_item,
    output logic      pop_valid,
    input  logic      pop_ready,
    output cls_item_t pop_item
);

    cls_item_t  mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/core/pwfd_back.sv -----
// Back end: frame state, bit shifting, transaction filter and output register.
module pwfd_back
    import pwfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [IDLE_W-1:0]  idle_reset_time,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  cls_item_t          pop_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               frame_is_word,
    output logic [VALUE_W-1:0] frame_value
);

    logic               awaiting_start_reg, awaiting_start_next;
    logic               pre_pulse_seen_reg, pre_pulse_seen_next;
    logic               long_frame_reg, long_frame_next;
    logic [COUNT_W-1:0] bits_taken_reg, bits_taken_next;
    logic [VALUE_W-1:0] shift_value_reg, shift_value_next;
    logic               byte_delivered_reg, byte_delivered_next;
    logic               word_delivered_reg, word_delivered_next;
    logic [TS_BITS-1:0] last_frame_time_reg, last_frame_time_next;
    logic               out_valid_reg, out_valid_next;
    logic               frame_is_word_reg;
    logic [VALUE_W-1:0] frame_value_reg;

    logic               take;
    logic               emit;
    logic               emit_word;
    logic [TS_BITS-1:0] elapsed;
    logic [COUNT_W-1:0] bits_inc;
    logic [VALUE_W-1:0] shift_inc;

    assign pop_ready     = !out_valid_reg || out_ready;
    assign take          = pop_valid && pop_ready;
    assign out_valid     = out_valid_reg;
    assign frame_is_word = frame_is_word_reg;
    assign frame_value   = frame_value_reg;
    assign elapsed       = pop_item.now - last_frame_time_reg;

    // Per-request state update
    always_comb
    begin
        awaiting_start_next  = awaiting_start_reg;
        pre_pulse_seen_next  = pre_pulse_seen_reg;
        long_frame_next      = long_frame_reg;
        bits_taken_next      = bits_taken_reg;
        shift_value_next     = shift_value_reg;
        byte_delivered_next  = byte_delivered_reg;
        word_delivered_next  = word_delivered_reg;
        last_frame_time_next = last_frame_time_reg;
        emit                 = 1'b0;
        emit_word            = 1'b0;
        bits_inc             = '0;
        shift_inc            = '0;

        if (take)
        begin
            // idle gap clears the transaction
            if (elapsed > TS_BITS'(idle_reset_time))
            begin
                byte_delivered_next = 1'b0;
                word_delivered_next = 1'b0;
            end

            if (awaiting_start_reg && pop_item.is_pre)
            begin
                pre_pulse_seen_next = 1'b1;
            end
            else
            begin
                if (pop_item.is_start)
                begin
                    long_frame_next     = pre_pulse_seen_reg;
                    pre_pulse_seen_next = 1'b0;
                    awaiting_start_next = 1'b0;
                    bits_taken_next     = '0;
                    shift_value_next    = '0;
                end

                if (!awaiting_start_next && pop_item.has_low)
                begin
                    shift_inc        = {shift_value_next[VALUE_W-2:0], pop_item.bit_one};
                    bits_inc         = bits_taken_next + COUNT_W'(1);
                    shift_value_next = shift_inc;
                    bits_taken_next  = bits_inc;

                    if (bits_inc == (long_frame_next ? WORD_BITS : BYTE_BITS))
                    begin
                        last_frame_time_next = pop_item.now;
                        if (!long_frame_next && !byte_delivered_next)
                        begin
                            emit                = 1'b1;
                            byte_delivered_next = 1'b1;
                        end
                        else if (long_frame_next && byte_delivered_next &&
                                 !word_delivered_next)
                        begin
                            emit                = 1'b1;
                            emit_word           = 1'b1;
                            word_delivered_next = 1'b1;
                        end
                        awaiting_start_next = 1'b1;
                        bits_taken_next     = '0;
                        shift_value_next    = '0;
                    end
                end
            end
        end
    end

    // Output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_start_reg  <= 1'b1;
            pre_pulse_seen_reg  <= 1'b0;
            long_frame_reg      <= 1'b0;
            bits_taken_reg      <= '0;
            shift_value_reg     <= '0;
            byte_delivered_reg  <= 1'b0;
            word_delivered_reg  <= 1'b0;
            last_frame_time_reg <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            awaiting_start_reg  <= awaiting_start_next;
            pre_pulse_seen_reg  <= pre_pulse_seen_next;
            long_frame_reg      <= long_frame_next;
            bits_taken_reg      <= bits_taken_next;
            shift_value_reg     <= shift_value_next;
            byte_delivered_reg  <= byte_delivered_next;
            word_delivered_reg  <= word_delivered_next;
            last_frame_time_reg <= last_frame_time_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // Result payload; byte frames keep the high byte zero
    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            frame_is_word_reg <= emit_word;
            frame_value_reg   <= emit_word ? shift_inc
                                           : {8'h00, shift_inc[7:0]};
        end
    end

`ifndef SYNTHESIS
    a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bits_taken_reg < WORD_BITS)
        else $error("bit count reached frame end without closing");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        awaiting_start_reg |-> (bits_taken_reg == '0 && shift_value_reg == '0))
        else $error("frame data left over while waiting for start");

    a_word_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
        word_delivered_reg |-> byte_delivered_reg)
        else $error("word delivered without a byte in the transaction");

    a_byte_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !frame_is_word_reg) |-> (frame_value_reg[15:8] == 8'h00))
        else $error("byte frame carries a nonzero high byte");
`endif

endmodule

// ----- rtl/core/pulse_width_frame_decoder.sv -----
// Path: a request accepted into the front stage register reaches out_valid through the queue
// write and the back-end output register when nothing stalls. Throughput: one pulse pair per
// cycle unless out_ready stalls; the back end updates frame state in the same cycle it takes a
// pair; a two-entry queue lets the front keep accepting while the output is held, until full.
// Reset (rst_n, async, active low) restores register defaults and clears frame state,
// transaction flags, last frame time and all valid flags; nothing needs a clearing pass.
module pulse_width_frame_decoder
    import pwfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  first_level,
    input  logic [DUR_W-1:0]      first_duration,
    input  logic                  second_level,
    input  logic [DUR_W-1:0]      second_duration,
    input  logic [TS_BITS-1:0]    arrival_time,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  frame_is_word,
    output logic [VALUE_W-1:0]    frame_value
);

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    logic      push_valid;
    logic      push_ready;
    cls_item_t push_item;
    logic      pop_valid;
    logic      pop_ready;
    cls_item_t pop_item;

    // Register file write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PRE_LOW_MIN:    cfg_next.pre_low_min     = cfg_data[DUR_W-1:0];
                CFG_PRE_LOW_MAX:    cfg_next.pre_low_max     = cfg_data[DUR_W-1:0];
                CFG_START_HIGH_MIN: cfg_next.start_high_min  = cfg_data[DUR_W-1:0];
                CFG_START_HIGH_MAX: cfg_next.start_high_max  = cfg_data[DUR_W-1:0];
                CFG_BIT_THRESHOLD:  cfg_next.bit_threshold   = cfg_data[DUR_W-1:0];
                CFG_IDLE_RESET:     cfg_next.idle_reset_time = cfg_data[IDLE_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pre_low_min     <= RST_PRE_LOW_MIN;
            cfg_reg.pre_low_max     <= RST_PRE_LOW_MAX;
            cfg_reg.start_high_min  <= RST_START_HIGH_MIN;
            cfg_reg.start_high_max  <= RST_START_HIGH_MAX;
            cfg_reg.bit_threshold   <= RST_BIT_THRESHOLD;
            cfg_reg.idle_reset_time <= RST_IDLE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pwfd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .first_level     (first_level),
        .first_duration  (first_duration),
        .second_level    (second_level),
        .second_duration (second_duration),
        .arrival_time    (arrival_time),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_item       (push_item)
    );

    pwfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    pwfd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .idle_reset_time (cfg_reg.idle_reset_time),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_item        (pop_item),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .frame_is_word   (frame_is_word),
        .frame_value     (frame_value)
    );

endmodule
